/* design/dcr_pkg.sv */
// Shared types and constants of the delta cepstrum ring.
`default_nettype none
package dcr_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register select is address bit 2 (registers sit at byte addresses 0 and 4).
   localparam logic CSR_VECTOR_LENGTH = 1'b0;
   localparam logic CSR_HALF_WINDOW   = 1'b1;

   localparam logic [5:0] VECTOR_LENGTH_RESET = 6'd12;
   localparam logic [2:0] HALF_WINDOW_RESET   = 3'd2;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_FLUSH = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] coef_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] static_value;
      logic signed [15:0] delta_value;
      logic [4:0]         coef_index;
      logic               frame_ready;
      logic               last_of_frame;
   } rsp_type;

endpackage
`default_nettype wire

/* design/dcr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module dcr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 288
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/delta_cepstrum_ring_top.sv */
// Top level of the delta cepstrum ring: frame store, sequencer and shared divider.
`default_nettype none
// Coefficients are pushed one word at a time into a RAM ring of 2*WIN_MAX+1 frames.
// A push that does not close a frame leaves the input ready for the next word, as do
// start words and configuration writes. A push that closes a frame, or a flush, goes
// to a check state; if the centre frame is valid, each coefficient is read, summed
// over W neighbour steps and divided, and may wait for the output register to free up,
// with W the active half window; the accumulator is SUM_W = 18 + 2*clog2(WIN_MAX+1)
// bits wide (24 at the default WIN_MAX). Each neighbour step costs two reads of the
// single RAM read port and an accumulate, and the quotient comes from a restoring
// divider that retires one bit per cycle. A flush with no valid centre frame goes
// through the check and empty states, and its single empty word waits there until
// the output register is free. Input is held off until the frame's last word is
// loaded into the output register; that word may still wait there while the next
// input words are taken. The ring RAM is not cleared; only valid frames are read.
module delta_cepstrum_ring_top #(
   parameter int VEC_MAX = 32,
   parameter int WIN_MAX = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire dcr_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output dcr_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [dcr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [dcr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dcr_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   import dcr_pkg::*;

   localparam int SLOTS   = 2 * WIN_MAX + 1;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int IDX_W   = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;
   localparam int LEN_W   = $clog2(VEC_MAX + 1);
   localparam int WIN_W   = $clog2(WIN_MAX + 1);
   localparam int DIFF_W  = 17;
   localparam int PROD_W  = DIFF_W + WIN_W + 1;
   localparam int SUM_W   = PROD_W + WIN_W;
   localparam int SQ_SUM  = WIN_MAX * (WIN_MAX + 1) * (2 * WIN_MAX + 1) / 6;
   localparam int DEN_W   = $clog2(2 * SQ_SUM + 1);
   localparam int CNT_W   = $clog2(SUM_W);
   localparam int DEPTH   = SLOTS << IDX_W;
   localparam int ADDR_W  = SLOT_W + IDX_W;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_CHECK     = 9'b000000010,
      S_RD_STATIC = 9'b000000100,
      S_RD_RIGHT  = 9'b000001000,
      S_RD_LEFT   = 9'b000010000,
      S_ACC       = 9'b000100000,
      S_DIV       = 9'b001000000,
      S_EMIT      = 9'b010000000,
      S_EMPTY     = 9'b100000000
   } state_type;

   // Twice the sum of squares 1..w.
   function automatic logic [DEN_W-1:0] denom_of(input logic [WIN_W-1:0] w);
      int s;
      s = 0;
      for (int i = 1; i <= WIN_MAX; i++) begin
         if (i <= int'(w)) begin
            s += i * i;
         end
      end
      return DEN_W'(2 * s);
   endfunction

   state_type              state_ff, state_in;
   logic [5:0]             vector_length_ff, vector_length_in;
   logic [2:0]             half_window_ff, half_window_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [SLOT_W-1:0]      store_ff, store_in;
   logic [IDX_W-1:0]       elem_ff, elem_in;
   logic                   flush_ff, flush_in;
   logic [SLOT_W-1:0]      cur_ff, cur_in;
   logic [SLOT_W-1:0]      pl_ff, pl_in;
   logic [SLOT_W-1:0]      pr_ff, pr_in;
   logic [SLOT_W-1:0]      lv_ff, lv_in;
   logic [SLOT_W-1:0]      rv_ff, rv_in;
   logic [IDX_W-1:0]       n_ff, n_in;
   logic [WIN_W-1:0]       t_ff, t_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic [15:0]            static_ff, static_in;
   logic [15:0]            right_ff, right_in;
   logic [DEN_W-1:0]       denom_ff, denom_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]       quo_ff, quo_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [LEN_W-1:0]       eff_len;
   logic [WIN_W-1:0]       eff_win;
   logic [SLOT_W-1:0]      slots_eff;
   logic [SLOT_W-1:0]      cur_calc;
   logic [SLOT_W:0]        cur_wrap;
   logic [SLOT_W-1:0]      store_next;
   logic [SLOT_W-1:0]      pr_next, pl_next, rv_next, lv_next;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [SUM_W-1:0]  acc_sum;
   logic [DEN_W:0]         trial;
   logic                   quo_bit;
   logic signed [15:0]     delta_sat;
   logic                   slot_free;
   logic                   cfg_we;
   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_ra;
   logic [15:0]            ram_rd;

   dcr_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ({store_ff, elem_ff}),
      .wr_data (req_data.coef_value),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Registers out of range act as the nearest value in range.
   always_comb begin
      if (vector_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (int'(vector_length_ff) > VEC_MAX) begin
         eff_len = LEN_W'(VEC_MAX);
      end else begin
         eff_len = LEN_W'(vector_length_ff);
      end
      if (half_window_ff == '0) begin
         eff_win = WIN_W'(1);
      end else if (int'(half_window_ff) > WIN_MAX) begin
         eff_win = WIN_W'(WIN_MAX);
      end else begin
         eff_win = WIN_W'(half_window_ff);
      end
   end

   assign slots_eff  = SLOT_W'({eff_win, 1'b1});
   assign cur_wrap   = (SLOT_W + 1)'(store_ff) + (SLOT_W + 1)'(slots_eff)
                     - (SLOT_W + 1)'(eff_win);
   assign cur_calc   = (store_ff >= SLOT_W'(eff_win)) ? SLOT_W'(store_ff - SLOT_W'(eff_win))
                                                      : SLOT_W'(cur_wrap);
   assign store_next = (SLOT_W'(store_ff + 1'b1) == slots_eff) ? '0
                                                               : SLOT_W'(store_ff + 1'b1);
   assign pr_next    = (SLOT_W'(pr_ff + 1'b1) == slots_eff) ? '0 : SLOT_W'(pr_ff + 1'b1);
   assign pl_next    = (pl_ff == '0) ? SLOT_W'(slots_eff - 1'b1) : SLOT_W'(pl_ff - 1'b1);
   // A neighbour that is not valid falls back to the nearest valid one nearer the centre.
   assign rv_next    = valid_ff[pr_next] ? pr_next : rv_ff;
   assign lv_next    = valid_ff[pl_next] ? pl_next : lv_ff;

   assign diff    = $signed({right_ff[15], right_ff}) - $signed({ram_rd[15], ram_rd});
   assign prod    = diff * $signed({1'b0, t_ff});
   assign acc_sum = acc_ff + SUM_W'(prod);

   assign trial   = {rem_ff, quo_ff[SUM_W-1]};
   assign quo_bit = (trial >= {1'b0, denom_ff});

   always_comb begin
      if (!neg_ff) begin
         delta_sat = (quo_ff > SUM_W'(32767)) ? 16'sh7FFF : $signed(16'(quo_ff));
      end else if (quo_ff > SUM_W'(32768)) begin
         delta_sat = 16'sh8000;
      end else begin
         delta_sat = $signed(16'(SUM_W'(0) - quo_ff));
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cfg_we    = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      state_in         = state_ff;
      vector_length_in = vector_length_ff;
      half_window_in   = half_window_ff;
      valid_in         = valid_ff;
      store_in         = store_ff;
      elem_in          = elem_ff;
      flush_in         = flush_ff;
      cur_in           = cur_ff;
      pl_in            = pl_ff;
      pr_in            = pr_ff;
      lv_in            = lv_ff;
      rv_in            = rv_ff;
      n_in             = n_ff;
      t_in             = t_ff;
      acc_in           = acc_ff;
      static_in        = static_ff;
      right_in         = right_ff;
      denom_in         = denom_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      neg_in           = neg_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;
      ram_we           = 1'b0;
      ram_ra           = {cur_ff, n_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.action)
                  ACT_PUSH: begin
                     ram_we = 1'b1;
                     if (LEN_W'(elem_ff) + LEN_W'(1) == eff_len) begin
                        elem_in            = '0;
                        valid_in[store_ff] = 1'b1;
                        flush_in           = 1'b0;
                        state_in           = S_CHECK;
                     end else begin
                        elem_in = IDX_W'(elem_ff + 1'b1);
                     end
                  end
                  ACT_FLUSH: begin
                     elem_in            = '0;
                     valid_in[store_ff] = 1'b0;
                     flush_in           = 1'b1;
                     state_in           = S_CHECK;
                  end
                  ACT_START: begin
                     valid_in = '0;
                     store_in = '0;
                     elem_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHECK: begin
            cur_in   = cur_calc;
            denom_in = denom_of(eff_win);
            n_in     = '0;
            store_in = store_next;
            if (valid_ff[cur_calc]) begin
               state_in = S_RD_STATIC;
            end else if (flush_ff) begin
               state_in = S_EMPTY;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD_STATIC: begin
            ram_ra   = {cur_ff, n_ff};
            lv_in    = cur_ff;
            rv_in    = cur_ff;
            pl_in    = cur_ff;
            pr_in    = cur_ff;
            t_in     = WIN_W'(1);
            acc_in   = '0;
            state_in = S_RD_RIGHT;
         end
         S_RD_RIGHT: begin
            // On the first step the read data is the centre's static coefficient.
            if (t_ff == WIN_W'(1)) begin
               static_in = ram_rd;
            end
            pr_in    = pr_next;
            pl_in    = pl_next;
            rv_in    = rv_next;
            lv_in    = lv_next;
            ram_ra   = {rv_next, n_ff};
            state_in = S_RD_LEFT;
         end
         S_RD_LEFT: begin
            right_in = ram_rd;
            ram_ra   = {lv_ff, n_ff};
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_sum;
            if (t_ff == eff_win) begin
               neg_in   = acc_sum[SUM_W-1];
               quo_in   = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);
               rem_in   = '0;
               cnt_in   = CNT_W'(SUM_W - 1);
               state_in = S_DIV;
            end else begin
               t_in     = WIN_W'(t_ff + 1'b1);
               state_in = S_RD_RIGHT;
            end
         end
         S_DIV: begin
            rem_in = quo_bit ? DEN_W'(trial - {1'b0, denom_ff}) : DEN_W'(trial);
            quo_in = {quo_ff[SUM_W-2:0], quo_bit};
            if (cnt_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               cnt_in = CNT_W'(cnt_ff - 1'b1);
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.static_value  = $signed(static_ff);
               rsp_in.delta_value   = delta_sat;
               rsp_in.coef_index    = 5'(n_ff);
               rsp_in.frame_ready   = 1'b1;
               rsp_in.last_of_frame = (LEN_W'(n_ff) + LEN_W'(1) == eff_len);
               if (LEN_W'(n_ff) + LEN_W'(1) == eff_len) begin
                  state_in = S_IDLE;
               end else begin
                  n_in     = IDX_W'(n_ff + 1'b1);
                  state_in = S_RD_STATIC;
               end
            end
         end
         S_EMPTY: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.last_of_frame = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A register write also restarts the utterance.
      if (cfg_we) begin
         if (csr_paddr[2] == CSR_VECTOR_LENGTH) begin
            vector_length_in = csr_pwdata[5:0];
         end else begin
            half_window_in = csr_pwdata[2:0];
         end
         valid_in = '0;
         store_in = '0;
         elem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         vector_length_ff <= VECTOR_LENGTH_RESET;
         half_window_ff   <= HALF_WINDOW_RESET;
         valid_ff         <= '0;
         store_ff         <= '0;
         elem_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         vector_length_ff <= vector_length_in;
         half_window_ff   <= half_window_in;
         valid_ff         <= valid_in;
         store_ff         <= store_in;
         elem_ff          <= elem_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_ff  <= flush_in;
      cur_ff    <= cur_in;
      pl_ff     <= pl_in;
      pr_ff     <= pr_in;
      lv_ff     <= lv_in;
      rv_ff     <= rv_in;
      n_ff      <= n_in;
      t_ff      <= t_in;
      acc_ff    <= acc_in;
      static_ff <= static_in;
      right_ff  <= right_in;
      denom_ff  <= denom_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_VECTOR_LENGTH) ? CSR_DATA_W'(vector_length_ff)
                                                           : CSR_DATA_W'(half_window_ff);

endmodule
`default_nettype wire

/* design/dcr_checker.sv */
// Port-level checks of the delta cepstrum ring, bound to the top level.
`default_nettype none
module dcr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire dcr_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire dcr_pkg::rsp_type rsp_data
);

   import dcr_pkg::*;

   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_ready |->
         rsp_data.last_of_frame && rsp_data.coef_index == 5'd0 &&
         rsp_data.static_value == 16'sd0 && rsp_data.delta_value == 16'sd0)
      else $error("empty flush word is malformed");

   a_frame_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_frame |-> !req_ready)
      else $error("input taken while a frame is still being emitted");

   a_start_returns: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.action == ACT_START |=> req_ready)
      else $error("start word did not return at once");

endmodule

bind delta_cepstrum_ring_top dcr_checker u_dcr_checker (.*);
`default_nettype wire
